FILE: rtl/core/dwd_pkg.sv
// Shared types for the double-word divider.
`default_nettype none

package dwd_pkg;

  // Control strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;   // capture a new input beat
    logic step;   // retire one quotient bit
    logic xfer;   // move the finished result into the output register
  } dwd_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/double_word_divider.sv
// Unsigned two-word by one-word divider, one quotient bit per cycle.
//
// Usage:
//   Input beat: in_dividend_high, in_dividend_low, in_divisor with in_valid /
//   in_ready. Result beat: out_quotient_high, out_quotient_low, out_remainder,
//   out_divide_by_zero with out_valid / out_ready.
//   A nonzero divisor runs the shift-subtract loop over all 2*WORD_BITS quotient
//   bits (128 at the default width), using the single restoring subtractor that
//   retires one quotient bit per cycle; the result then moves into the output
//   register once that register is free.
//   A zero divisor skips the bit loop and goes straight to the hand-off,
//   with quotient all ones, remainder equal to the low dividend word and
//   out_divide_by_zero set.
//   One item is in work at a time; in_ready returns once the result has
//   moved to the output register, so a new beat is taken while the previous
//   result still waits.
//   If the receiver stalls with a result still held, the finished item waits
//   in the unit and in_ready stays low until the output register frees.
//   Reset (rst_n low, synchronous) drops any item in work and any held result.
`default_nettype none

module double_word_divider #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WORD_BITS-1:0] in_dividend_high,
  input  wire logic [WORD_BITS-1:0] in_dividend_low,
  input  wire logic [WORD_BITS-1:0] in_divisor,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [WORD_BITS-1:0] out_quotient_high,
  output logic      [WORD_BITS-1:0] out_quotient_low,
  output logic      [WORD_BITS-1:0] out_remainder,
  output logic                      out_divide_by_zero
);

  dwd_pkg::dwd_ctl_t ctl;
  logic              div_zero;

  // Flag a zero divisor on the incoming beat
  assign div_zero = (in_divisor == '0);

  dwd_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .div_zero  (div_zero),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  dwd_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk                (clk),
    .ctl                (ctl),
    .div_zero           (div_zero),
    .in_dividend_high   (in_dividend_high),
    .in_dividend_low    (in_dividend_low),
    .in_divisor         (in_divisor),
    .out_quotient_high  (out_quotient_high),
    .out_quotient_low   (out_quotient_low),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dwd_datapath.sv
// Bit-serial restoring shift-subtract datapath with result register.
`default_nettype none

module dwd_datapath #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire dwd_pkg::dwd_ctl_t    ctl,
  input  wire logic                 div_zero,
  input  wire logic [WORD_BITS-1:0] in_dividend_high,
  input  wire logic [WORD_BITS-1:0] in_dividend_low,
  input  wire logic [WORD_BITS-1:0] in_divisor,
  output logic      [WORD_BITS-1:0] out_quotient_high,
  output logic      [WORD_BITS-1:0] out_quotient_low,
  output logic      [WORD_BITS-1:0] out_remainder,
  output logic                      out_divide_by_zero
);

  // Dividend bits shift out at the top while quotient bits fill in at the bottom
  logic [2*WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0]   rem_r;
  logic [WORD_BITS-1:0]   dvs_r;
  logic                   dz_r;

  logic [WORD_BITS-1:0]   rem_shift;
  logic [WORD_BITS:0]     diff;
  logic                   carry;
  logic                   take;

  // Form the trial subtraction for the current bit
  always_comb begin
    carry     = rem_r[WORD_BITS-1];
    rem_shift = {rem_r[WORD_BITS-2:0], acc_r[2*WORD_BITS-1]};
    diff      = {carry, rem_shift} - {1'b0, dvs_r};
    take      = carry | ~diff[WORD_BITS];
  end

  // Load, advance one bit, or hold
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvs_r <= in_divisor;
      dz_r  <= div_zero;
      if (div_zero) begin
        acc_r <= '1;
        rem_r <= in_dividend_low;
      end else begin
        acc_r <= {in_dividend_high, in_dividend_low};
        rem_r <= '0;
      end
    end else if (ctl.step) begin
      acc_r <= {acc_r[2*WORD_BITS-2:0], take};
      rem_r <= take ? diff[WORD_BITS-1:0] : rem_shift;
    end
  end

  // Result register parts the working unit from the receiver
  always_ff @(posedge clk) begin
    if (ctl.xfer) begin
      out_quotient_high  <= acc_r[2*WORD_BITS-1:WORD_BITS];
      out_quotient_low   <= acc_r[WORD_BITS-1:0];
      out_remainder      <= rem_r;
      out_divide_by_zero <= dz_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dwd_ctrl.sv
// Sequencer: bit counter, handshakes and result-valid flag.
`default_nettype none

module dwd_ctrl #(
  parameter int WORD_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              div_zero,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dwd_pkg::dwd_ctl_t      ctl
);

  localparam int CNT_BITS = $clog2(2*WORD_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t              state_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                out_valid_r;

  // Decode strobes from state
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    ctl.load  = in_valid && in_ready;
    ctl.step  = (state_r == ST_RUN);
    ctl.xfer  = (state_r == ST_HOLD) && (!out_valid_r || out_ready);
  end

  // Advance state, count bits, track the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (ctl.load) begin
            cnt_r   <= CNT_BITS'(2*WORD_BITS-1);
            state_r <= div_zero ? ST_HOLD : ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r - CNT_BITS'(1);
          if (cnt_r == '0) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (ctl.xfer) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (ctl.xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // An accepted beat keeps the unit busy on the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> !in_ready)
    else $error("unit took a beat and was not busy");

  // The last bit step leads into the hand-off state
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == '0) |=> (state_r == ST_HOLD))
    else $error("bit count ran out without finishing");

  // A hand-off always raises the result-valid flag
  a_xfer_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.xfer |=> out_valid)
    else $error("result moved but not shown");

  // Never step the datapath while taking a new beat
  a_no_step_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.step && ctl.load))
    else $error("load and step together");
`endif

endmodule

`default_nettype wire

FILE: sim/dwd_result_checker.sv
// Result checker for the double-word divider: predicts quotient and remainder per beat and compares.
`timescale 1ns / 1ps

module dwd_result_checker #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_dividend_high,
  input  logic [WORD_BITS-1:0] in_dividend_low,
  input  logic [WORD_BITS-1:0] in_divisor,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [WORD_BITS-1:0] out_quotient_high,
  input  logic [WORD_BITS-1:0] out_quotient_low,
  input  logic [WORD_BITS-1:0] out_remainder,
  input  logic                 out_divide_by_zero,
  output int                   failures,
  output int                   outstanding
);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t quo_high;
    word_t quo_low;
    word_t rem;
    logic  by_zero;
  } division_t;

  division_t pending_divisions[$];
  int        error_count   = 0;
  int        pending_count = 0;

  assign failures    = error_count;
  assign outstanding = pending_count;

  // Divide the two-word dividend by the one-word divisor; a zero divisor gives
  // an all-ones quotient, the low dividend word as remainder and the flag.
  function automatic division_t divide_words(word_t num_high, word_t num_low, word_t div);
    logic [2*WORD_BITS-1:0] num;
    logic [2*WORD_BITS-1:0] quo;
    logic [2*WORD_BITS-1:0] rem;
    division_t              res;
    num = {num_high, num_low};
    if (div == '0) begin
      res.quo_high = '1;
      res.quo_low  = '1;
      res.rem      = num_low;
      res.by_zero  = 1'b1;
    end else begin
      quo          = num / {{WORD_BITS{1'b0}}, div};
      rem          = num % {{WORD_BITS{1'b0}}, div};
      res.quo_high = quo[2*WORD_BITS-1:WORD_BITS];
      res.quo_low  = quo[WORD_BITS-1:0];
      res.rem      = rem[WORD_BITS-1:0];
      res.by_zero  = 1'b0;
    end
    return res;
  endfunction

  task automatic report_failure(string msg);
    $display("[%0t] %s", $time, msg);
    error_count++;
  endtask

  // Compare each result beat with the oldest prediction, then queue new ones
  always @(posedge clk) begin
    division_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_divisions.size() == 0) begin
          report_failure($sformatf("result beat with no division pending: q=%h_%h r=%h z=%b",
                                   out_quotient_high, out_quotient_low, out_remainder,
                                   out_divide_by_zero));
        end else begin
          want = pending_divisions.pop_front();
          if (out_quotient_high !== want.quo_high)
            report_failure($sformatf("quotient_high: got %h expected %h",
                                     out_quotient_high, want.quo_high));
          if (out_quotient_low !== want.quo_low)
            report_failure($sformatf("quotient_low: got %h expected %h",
                                     out_quotient_low, want.quo_low));
          if (out_remainder !== want.rem)
            report_failure($sformatf("remainder: got %h expected %h",
                                     out_remainder, want.rem));
          if (out_divide_by_zero !== want.by_zero)
            report_failure($sformatf("divide_by_zero: got %b expected %b",
                                     out_divide_by_zero, want.by_zero));
        end
      end
      if (in_valid && in_ready)
        pending_divisions.push_back(divide_words(in_dividend_high, in_dividend_low, in_divisor));
      pending_count = pending_divisions.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Testbench top: drives division beats into the double-word divider and reports the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int WORD_BITS    = 64;
  localparam int LATENCY      = 2 * WORD_BITS + 2;
  localparam int RANDOM_BEATS = 1500;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic  clk                = 1'b0;
  logic  rst_n              = 1'b0;
  logic  in_valid           = 1'b0;
  logic  in_ready;
  word_t in_dividend_high   = '0;
  word_t in_dividend_low    = '0;
  word_t in_divisor         = '0;
  logic  out_valid;
  logic  out_ready          = 1'b0;
  word_t out_quotient_high;
  word_t out_quotient_low;
  word_t out_remainder;
  logic  out_divide_by_zero;
  int    failures;
  int    outstanding;
  bit    calm               = 1'b0;

  double_word_divider #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_dividend_high,
    .in_dividend_low,
    .in_divisor,
    .out_valid,
    .out_ready,
    .out_quotient_high,
    .out_quotient_low,
    .out_remainder,
    .out_divide_by_zero
  );

  dwd_result_checker #(
    .WORD_BITS(WORD_BITS)
  ) result_check (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_dividend_high,
    .in_dividend_low,
    .in_divisor,
    .out_valid,
    .out_ready,
    .out_quotient_high,
    .out_quotient_low,
    .out_remainder,
    .out_divide_by_zero,
    .failures,
    .outstanding
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic word_t random_word();
    return {$urandom, $urandom};
  endfunction

  // Present one beat, idling first at random, and hold it until accepted
  task automatic send_division(word_t num_high, word_t num_low, word_t div);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, LATENCY + 2)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_dividend_high <= num_high;
    in_dividend_low  <= num_low;
    in_divisor       <= div;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mix divisor sizes and keep many high words below the divisor
  task automatic send_random_division();
    word_t div;
    word_t num_high;
    word_t num_low;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       div = '0;
    else if (pick < 8)  div = word_t'(1);
    else if (pick < 11) div = '1;
    else if (pick < 15) div = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
    else                div = random_word() >> $urandom_range(0, WORD_BITS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 45)      num_high = (div == '0) ? random_word() : random_word() % div;
    else if (pick < 80) num_high = random_word();
    else if (pick < 90) num_high = '0;
    else                num_high = '1;
    pick = $urandom_range(0, 99);
    if (pick < 85)      num_low = random_word();
    else if (pick < 93) num_low = '0;
    else                num_low = '1;
    send_division(num_high, num_low, div);
  endtask

  // Receiver: short random stalls, rare long ones, none in the calm stretch
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3999) == 0) begin
        stall_left = $urandom_range(1, 3 * LATENCY);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin
    // Hold reset low, then release it on a falling clock edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero divisor
    send_division(random_word(), random_word(), '0);
    send_division('1, '1, '0);
    send_division('0, '0, '0);
    // Divisor one gives the dividend back
    send_division('1, '1, word_t'(1));
    send_division(random_word(), random_word(), word_t'(1));
    // Largest divisor, with high words at and below it
    send_division('1, '1, '1);
    send_division('1 - word_t'(1), '1, '1);
    send_division('0, '1, '1);
    // Top-bit divisor drives the carry out of the partial remainder
    send_division('1, '1, TOP_BIT);
    send_division(TOP_BIT - word_t'(1), '1, TOP_BIT);
    send_division('1, '0, TOP_BIT | word_t'(1));
    // Zero dividend, dividend equal to and below the divisor
    send_division('0, '0, random_word() | word_t'(1));
    send_division('0, word_t'(64'h0123_4567_89ab_cdef), word_t'(64'h0123_4567_89ab_cdef));
    send_division('0, word_t'(5), word_t'(7));
    // Small divisors over a full dividend
    send_division('1, '1, word_t'(2));
    send_division(random_word(), random_word(), word_t'(3));
    send_division(random_word(), random_word(), word_t'(64'h1_0000_0001));

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 600 && n < 900);
      send_random_division();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then watch for stray result beats
    wait (outstanding == 0);
    repeat (LATENCY + 4) @(negedge clk);
    if (failures == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
